// ----- src/lss_pkg.sv -----
// Shared constants, the configuration type and the case-fold helper for the line substring search.
package lss_pkg;

  // Default sizes handed to the top level as parameter defaults.
  localparam int PATTERN_MAX_DEF = 16;
  localparam int LINE_MAX_DEF    = 1024;

  // Fixed field and register widths.
  localparam int CHAR_W      = 8;
  localparam int TAG_W       = 16;
  localparam int MATCH_COL_W = 10;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int PLEN_W      = 5;
  localparam int PATTERN_W   = 2 * CFG_DATA_W;

  // Mask applied to the case-sensitivity register before use.
  localparam logic CASE_MASK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 2'd3;

  // Live search settings as seen by the datapath.
  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;  // byte k in bits 8k+7:8k
    logic [PLEN_W-1:0]    len;      // effective length, 1 to PATTERN_MAX
    logic                 exact;    // 1 means compare bytes exactly
  } lss_cfg_t;

  // Folds ASCII upper-case letters to lower case unless an exact compare is asked for.
  function automatic logic [CHAR_W-1:0] lss_fold(input logic [CHAR_W-1:0] c,
                                                  input logic exact);
    logic [CHAR_W-1:0] res;
    res = c;
    if (!exact && c >= 8'h41 && c <= 8'h5A) begin
      res = c + 8'h20;
    end
    return res;
  endfunction

endpackage

// ----- src/lss_cfg.sv -----
// Configuration register bank of the line substring search.
module lss_cfg
  import lss_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output lss_cfg_t              cfg
);

  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;
  logic [PLEN_W-1:0]     pattern_length_r;
  logic                  case_sensitive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= PLEN_W'(1);
      case_sensitive_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[PLEN_W-1:0];
        REG_CASE_SENSITIVE: case_sensitive_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one; lengths beyond the window saturate.
  always_comb begin
    cfg.pattern = {pattern_high_r, pattern_low_r};
    cfg.exact   = case_sensitive_r & CASE_MASK;
    if (pattern_length_r == '0) begin
      cfg.len = PLEN_W'(1);
    end else if (pattern_length_r > PLEN_W'(PATTERN_MAX)) begin
      cfg.len = PLEN_W'(PATTERN_MAX);
    end else begin
      cfg.len = pattern_length_r;
    end
  end

endmodule

// ----- src/lss_match.sv -----
// Parallel byte compare of the window tail against the pattern.
module lss_match
  import lss_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic [PATTERN_MAX-1:0][CHAR_W-1:0] win,  // entry 0 is the newest character
  input  lss_cfg_t                           cfg,
  output logic                               hit
);

  logic [PATTERN_MAX-1:0][CHAR_W-1:0] sel;
  logic [PATTERN_MAX-1:0]             ok;

  // Pattern byte k lines up with window entry len-1-k.
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      sel[k] = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (j + k + 1 == int'(cfg.len)) begin
          sel[k] = sel[k] | win[j];
        end
      end
      ok[k] = (k >= int'(cfg.len)) ||
              (lss_fold(sel[k], cfg.exact) == lss_fold(cfg.pattern[8*k +: 8], cfg.exact));
    end
    hit = &ok;
  end

endmodule

// ----- src/line_substring_search.sv -----
// Top level of the line substring search: input register, search state and result register.
//
// Characters of a text line arrive one per transaction on the in_ stream, the final one
// flagged by in_tlast, and the block reports at most one result per line: whether the
// configured pattern (1 to PATTERN_MAX bytes, optionally compared with ASCII letters
// folded to lower case) occurs wholly inside the line, the column where its first
// occurrence starts, and the tag of the line's last character. A match that ends on the
// last character counts, and no match spans two lines. Only the first LINE_MAX characters
// of a line are searched. The block takes one character per clock cycle unless the input
// side stalls: a character is registered on acceptance and compared against the pattern
// as it leaves the input register, and out_tvalid for a line's result rises as its last
// character leaves it. Throughput is set by the window shift plus parallel compare; the
// input side stalls only when a finished result still waits in the output register and
// another line end needs to land there. The user must write configuration via the cfg_
// port while no line is in flight (unenforced); writes act at once and need no reset pass.
module line_substring_search
  import lss_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int LINE_MAX    = LINE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [7:0] char_in, [23:8] line_tag
  input  logic                  in_tlast,   // last_in_line
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [0] found, [10:1] match_column,
                                            // [26:11] line_tag_out, [31:27] zero
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(LINE_MAX + 1);

  lss_cfg_t cfg;

  // Input register
  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;
  logic [TAG_W-1:0]  in_tag_r;

  // Per-line search state
  logic [PATTERN_MAX-1:0][CHAR_W-1:0] win_r;
  logic [COL_W-1:0]                   col_r;
  logic                               hit_valid_r;
  logic [COL_W-1:0]                   hit_col_r;

  // Result register
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [MATCH_COL_W-1:0] out_col_r;
  logic [TAG_W-1:0]       out_tag_r;

  logic                               fire;
  logic                               active;
  logic                               long_enough;
  logic                               cmp_hit;
  logic                               new_hit;
  logic [COL_W-1:0]                   new_hit_col;
  logic [PATTERN_MAX-1:0][CHAR_W-1:0] win_nxt;
  logic                               found_nxt;
  logic [COL_W-1:0]                   col_sel;
  logic [COL_W+MATCH_COL_W-1:0]       col_wide;

  lss_cfg #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The registered character is processed when it causes no result, or when the result
  // register is free or being emptied in this cycle.
  assign fire      = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  // Characters beyond LINE_MAX leave the window and the column count untouched.
  assign active = col_r < COL_W'(LINE_MAX);

  always_comb begin
    win_nxt[0] = in_char_r;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  lss_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .win (win_nxt),
    .cfg (cfg),
    .hit (cmp_hit)
  );

  // The window holds a full pattern once col_r + 1 >= len.
  assign long_enough = ((COL_W+1)'(col_r) + (COL_W+1)'(1)) >= (COL_W+1)'(cfg.len);
  assign new_hit     = active && !hit_valid_r && long_enough && cmp_hit;
  assign new_hit_col = col_r + COL_W'(1) - COL_W'(cfg.len);

  assign found_nxt = hit_valid_r || new_hit;
  assign col_sel   = hit_valid_r ? hit_col_r : (new_hit ? new_hit_col : '0);
  assign col_wide  = (COL_W+MATCH_COL_W)'(col_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      win_r       <= '0;
      col_r       <= '0;
      hit_valid_r <= 1'b0;
      hit_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end

      if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (fire) begin
        if (in_last_r) begin
          // End of line: publish the result and start the next line from scratch.
          out_valid_r <= 1'b1;
          win_r       <= '0;
          col_r       <= '0;
          hit_valid_r <= 1'b0;
          hit_col_r   <= '0;
        end else if (active) begin
          win_r <= win_nxt;
          col_r <= col_r + COL_W'(1);
          if (new_hit) begin
            hit_valid_r <= 1'b1;
            hit_col_r   <= new_hit_col;
          end
        end
      end
    end
  end

  // Payload registers, loaded alongside their valid flags.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
      in_tag_r  <= in_tdata[23:8];
    end
    if (fire && in_last_r) begin
      out_found_r <= found_nxt;
      out_col_r   <= col_wide[MATCH_COL_W-1:0];
      out_tag_r   <= in_tag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_tag_r, out_col_r, out_found_r};

  // A result only appears after a line end was processed in the previous cycle.
  a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && in_last_r))
    else $error("result raised without a processed line end");

  // A line that held no match reports column zero.
  a_no_match_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_col_r == '0))
    else $error("column nonzero on a line without a match");

  // The column count never runs past the searched part of the line.
  a_col_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(LINE_MAX))
    else $error("column count beyond LINE_MAX");

  // Every line end clears the per-line state.
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_r) |=> (col_r == '0 && !hit_valid_r))
    else $error("line state not cleared after line end");

endmodule

// ----- test/tb_line_substring_search.sv -----
// Self-checking testbench for the line substring search block.
`timescale 1ns / 1ps

module tb_line_substring_search
  import lss_pkg::*;
;

  localparam int LINE_LIMIT = 1024;  // characters searched per line
  localparam int PAT_CAP    = 16;    // longest pattern the block compares

  typedef logic [7:0] char_q_t[$];

  // One line result as the block reports it.
  typedef struct packed {
    logic       found;
    logic [9:0] column;
    logic [15:0] tag;
  } line_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // [7:0] char_in, [23:8] line_tag
  logic                  in_tlast;   // last_in_line
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;  // [0] found, [10:1] match_column,
                                     // [26:11] line_tag_out, [31:27] zero
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  line_substring_search DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the configuration registers, updated as each write goes out.
  logic [63:0] shadow_pat_low;
  logic [63:0] shadow_pat_high;
  logic [4:0]  shadow_pat_len;
  logic        shadow_exact;

  // Search state of the line currently streaming in.
  logic [7:0]  search_window[PAT_CAP];
  int          column_index;
  logic        hit_recorded;
  int          hit_column;

  // Pattern bytes chosen for the random traffic; used to plant occurrences.
  logic [7:0]  planted_pat[PAT_CAP];

  line_result_t expected_lines[$];
  line_result_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int chars_sent;
  int lines_sent;
  int lines_checked;
  int lines_found;

  always #10 clk = ~clk;

  // The receiver decides its ready at each falling edge, so a stall can land on
  // any cycle of a result's life in the output register.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
    err_count++;
  endtask

  // Result checker: every accepted result is matched against the oldest
  // outstanding line, field by field.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("result with no line outstanding", out_tdata, 32'h0);
      end else begin
        want = expected_lines.pop_front();
        lines_checked++;
        if (want.found) lines_found++;
        if (out_tdata[0] !== want.found)
          report_mismatch("found", 32'(out_tdata[0]), 32'(want.found));
        if (out_tdata[10:1] !== want.column)
          report_mismatch("match_column", 32'(out_tdata[10:1]), 32'(want.column));
        if (out_tdata[26:11] !== want.tag)
          report_mismatch("line_tag_out", 32'(out_tdata[26:11]), 32'(want.tag));
        if (out_tdata[31:27] !== 5'd0)
          report_mismatch("tdata padding", 32'(out_tdata[31:27]), 32'h0);
      end
    end
  end

  // ASCII upper case folds to lower case unless the compare is exact.
  function automatic logic [7:0] case_fold(input logic [7:0] c, input logic exact);
    if (!exact && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pattern_byte(input int k);
    logic [127:0] pat;
    pat = {shadow_pat_high, shadow_pat_low};
    return pat[8*k +: 8];
  endfunction

  // Length zero behaves as one; anything above the cap saturates.
  function automatic int active_pattern_len(input logic [4:0] raw);
    if (raw == 5'd0) return 1;
    if (raw > PAT_CAP) return PAT_CAP;
    return int'(raw);
  endfunction

  function automatic void clear_line_state();
    foreach (search_window[i]) search_window[i] = 8'h00;
    column_index = 0;
    hit_recorded = 1'b0;
    hit_column   = 0;
  endfunction

  // Advances the search by one accepted character and queues the line result
  // when the character closes the line.
  function automatic void track_char(input logic [7:0] c, input logic last,
                                     input logic [15:0] tag);
    int len;
    logic matched;
    line_result_t res;
    if (column_index < LINE_LIMIT) begin
      len = active_pattern_len(shadow_pat_len);
      for (int i = PAT_CAP - 1; i > 0; i--) search_window[i] = search_window[i-1];
      search_window[0] = c;
      if (!hit_recorded && column_index + 1 >= len) begin
        matched = 1'b1;
        // The oldest character of the candidate sits deepest in the window.
        for (int k = 0; k < len; k++) begin
          if (case_fold(search_window[len-1-k], shadow_exact) !=
              case_fold(pattern_byte(k), shadow_exact))
            matched = 1'b0;
        end
        if (matched) begin
          hit_recorded = 1'b1;
          hit_column   = column_index + 1 - len;
        end
      end
      column_index++;
    end
    if (last) begin
      res.found  = hit_recorded;
      res.column = hit_recorded ? hit_column[9:0] : 10'd0;
      res.tag    = tag;
      expected_lines.push_back(res);
      clear_line_state();
    end
  endfunction

  // Sends one character. Entered and left just after a falling edge.
  task automatic send_char(input logic [7:0] c, input logic last, input logic [15:0] tag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))};
      in_tlast  <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tag, c};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_char(c, last, tag);
    chars_sent++;
    @(negedge clk);
  endtask

  // Sends a whole line; only the final character's tag reaches the result.
  task automatic send_line(input char_q_t chars, input logic [15:0] tag);
    for (int i = 0; i < chars.size(); i++) begin
      if (i == chars.size() - 1) send_char(chars[i], 1'b1, tag);
      else send_char(chars[i], 1'b0, 16'($urandom_range(0, 65535)));
    end
    lines_sent++;
  endtask

  function automatic char_q_t text_line(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [127:0] text_pattern(input string s);
    logic [127:0] p;
    p = '0;
    for (int i = 0; i < s.len() && i < PAT_CAP; i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  // Waits until every outstanding line has reported, then lets the pipeline
  // settle before anything touches the registers.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    case (idx)
      REG_PATTERN_LOW:    shadow_pat_low  = data;
      REG_PATTERN_HIGH:   shadow_pat_high = data;
      REG_PATTERN_LENGTH: shadow_pat_len  = data[4:0];
      REG_CASE_SENSITIVE: shadow_exact    = data[0];
      default: ;
    endcase
  endtask

  // Writes all four registers back to back; the caller makes sure the block is idle.
  task automatic set_config(input logic [127:0] pat, input logic [63:0] len_word,
                            input logic [63:0] case_word);
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_CASE_SENSITIVE, case_word);
    cfg_wr_en <= 1'b0;
  endtask

  // Reset leaves a one-byte pattern of 0x00 with exact compare.
  task automatic test_reset_defaults();
    char_q_t q;
    q = '{8'h41, 8'h00};
    send_line(q, 16'h0000);
    q = '{8'hFF};
    send_line(q, 16'hFFFF);
    wait_idle();
  endtask

  // All-ones pattern bytes, length saturation above the cap and length zero.
  task automatic test_pattern_extremes();
    char_q_t q;
    set_config({128{1'b1}}, 64'd31, 64'd1);
    q = {};
    repeat (PAT_CAP) q.push_back(8'hFF);
    // The full-length match ends on the line's final character.
    send_line(q, 16'hA5A5);
    wait_idle();
    set_config({{120{1'b1}}, 8'h71}, 64'd0, 64'd1);
    send_line(text_line("aq"), 16'h5A5A);
    wait_idle();
  endtask

  // Case folding touches A..Z only: '@' and '[' sit just outside the range.
  task automatic test_case_folding();
    set_config(text_pattern("A@Z["), 64'd4, 64'd0);
    send_line(text_line("a@z["), 16'h0101);
    send_line(text_line("a`z{"), 16'h0102);
    wait_idle();
    set_config(text_pattern("A@Z["), 64'd4, 64'd1);
    send_line(text_line("a@z["), 16'h0103);
    send_line(text_line("A@Z["), 16'h0104);
    wait_idle();
    // Only bit 0 of the mode register counts, so 2 means ignore case.
    set_config(text_pattern("A@Z["), 64'd4, 64'd2);
    send_line(text_line("xA@z["), 16'h0105);
    wait_idle();
  endtask

  // A match may not span two lines, and only the first occurrence is reported.
  task automatic test_line_boundaries();
    set_config(text_pattern("ab"), 64'd2, 64'd1);
    send_line(text_line("xa"), 16'h0201);
    send_line(text_line("bx"), 16'h0202);
    send_line(text_line("abab"), 16'h0203);
    wait_idle();
  endtask

  // A line longer than the search limit: a match crossing the limit or lying
  // past it does not count, and the next line starts clean.
  task automatic test_overlong_lines();
    char_q_t q;
    set_config(text_pattern("kk"), 64'd2, 64'd1);
    q = {};
    for (int i = 0; i < 1060; i++)
      q.push_back((i == 1023 || i == 1024 || i == 1040 || i == 1041) ? "k" : "a");
    send_line(q, 16'h0302);
    send_line(text_line("kk"), 16'h0303);
    wait_idle();
  endtask

  // Mostly letters from a tiny alphabet so patterns and near misses are common.
  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: return "a";
        1: return "b";
        2: return "A";
        default: return "B";
      endcase
    end
    if (pick < 80) return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                               : 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return c ^ 8'h20;
    return c;
  endfunction

  task automatic random_config();
    logic [127:0] pat;
    logic [63:0] len_word;
    logic [63:0] case_word;
    int pick;
    for (int k = 0; k < PAT_CAP; k++) begin
      planted_pat[k] = random_char();
      pat[8*k +: 8]  = planted_pat[k];
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) len_word = 64'($urandom_range(1, 4));
    else if (pick < 90) len_word = 64'($urandom_range(5, 16));
    else if (pick < 95) len_word = 64'd0;
    else len_word = 64'($urandom_range(17, 31));
    // Upper bits of the length and mode words carry junk now and then.
    if ($urandom_range(0, 3) == 0) len_word[63:5] = 59'({$urandom, $urandom});
    case_word = 64'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) case_word[63:1] = 63'({$urandom, $urandom});
    set_config(pat, len_word, case_word);
  endtask

  // Builds a line of random content; most lines carry a planted occurrence,
  // some only a truncated one.
  task automatic random_line();
    char_q_t q;
    int len;
    int plen;
    int pos;
    int pick;
    len  = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
    plen = active_pattern_len(shadow_pat_len);
    q = {};
    repeat (len) q.push_back(random_char());
    pick = $urandom_range(0, 99);
    if (pick < 75 && len >= plen) begin
      pos = ($urandom_range(0, 4) == 0) ? len - plen : $urandom_range(0, len - plen);
      // A truncated copy leaves the last pattern byte out.
      for (int k = 0; k < plen; k++) begin
        if (pick >= 60 && k == plen - 1) break;
        q[pos+k] = $urandom_range(0, 1) ? flip_case(planted_pat[k]) : planted_pat[k];
      end
    end
    send_line(q, 16'($urandom_range(0, 65535)));
  endtask

  // Random traffic under one idling setting, with fresh registers every few lines.
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int n_chars);
    int start_count;
    start_count   = chars_sent;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    while (chars_sent - start_count < n_chars) begin
      wait_idle();
      random_config();
      repeat ($urandom_range(1, 6)) random_line();
    end
    wait_idle();
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    shadow_pat_low  = '0;
    shadow_pat_high = '0;
    shadow_pat_len  = 5'd1;
    shadow_exact    = 1'b1;
    clear_line_state();
    send_idle_pct = 16;
    recv_idle_pct = 49;
    err_count     = 0;
    chars_sent    = 0;
    lines_sent    = 0;
    lines_checked = 0;
    lines_found   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_pattern_extremes();
    test_case_folding();
    test_line_boundaries();
    test_overlong_lines();
    test_random_traffic(16, 49, 150);
    test_random_traffic(49, 16, 150);
    test_random_traffic(0, 0, 150);

    repeat (8) @(negedge clk);
    $display("Streamed %0d characters in %0d lines; %0d line results checked, %0d with a hit.",
             chars_sent, lines_sent, lines_checked, lines_found);
    $display("Covered reset values, length limits, case folding, line ends and overlong lines.");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Safety net in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("Timed out with %0d line results still outstanding.", expected_lines.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
